// ----- rtl/dtq_pkg.sv -----
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int TIME_W       = 48;
  localparam int HANDLE_W     = 8;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W        = $clog2(RESULT_LIMIT);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    ST_RELEASED = 1'b0,
    ST_REJECTED = 1'b1
  } status_t;

  // One classified command: key is the deadline of an add or the time of a tick.
  typedef struct packed {
    op_t                 op;
    logic [TIME_W-1:0]   key;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic             releasing;
    logic [CNT_W-1:0] count;
  } back_status_t;

endpackage

// ----- rtl/dtq_front.sv -----
`timescale 1ns / 1ps

module dtq_front import dtq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                kind,
  input  logic [TIME_W-1:0]   deadline,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [TIME_W-1:0]   current_time,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_take
);

  cmd_t                  fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;
  cmd_t                  cmd_in;
  logic                  push;
  logic                  pop;

  // Classify: pick the time field that the command actually uses.
  always_comb begin
    cmd_in.op     = op_t'(kind);
    cmd_in.key    = kind ? current_time : deadline;
    cmd_in.handle = handle;
  end

  assign item_stall = (fill == FIFO_CNT_W'(FIFO_DEPTH));
  assign push       = item_valid && !item_stall;
  assign pop        = cmd_take && cmd_valid;
  assign cmd_valid  = (fill != '0);
  assign cmd        = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/dtq_back.sv -----
`timescale 1ns / 1ps

module dtq_back import dtq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_take,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                status,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [TIME_W-1:0]   out_deadline,
  output logic                last,
  output back_status_t        bstat
);

  typedef enum logic {
    S_IDLE,
    S_REL
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [REL_W-1:0]    rel_n;
  logic [TIME_W-1:0]   now_r;

  logic [TIME_W-1:0]   cell_dl [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] cell_hd [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] prev_gt;

  logic out_free;
  logic full;
  logic do_insert;
  logic do_reject;
  logic do_start;
  logic head_exp;
  logic next_exp;
  logic do_pop;

  assign out_free  = !result_valid || !result_stall;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign cmd_take  = (state == S_IDLE) && cmd_valid && out_free;
  assign do_insert = cmd_take && (cmd.op == OP_ADD) && !full;
  assign do_reject = cmd_take && (cmd.op == OP_ADD) && full;
  assign do_start  = cmd_take && (cmd.op == OP_TICK);

  assign head_exp = (count != '0) && (cell_dl[0] <= now_r);
  assign next_exp = (count > CNT_W'(1)) && (cell_dl[1] <= now_r) &&
                    (rel_n != REL_W'(RESULT_LIMIT - 1));
  assign do_pop   = (state == S_REL) && head_exp && out_free;

  assign bstat.releasing = (state == S_REL);
  assign bstat.count     = count;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      // Cells after the new timer's place move up one.
      assign gt[gi] = (count > CNT_W'(gi)) && (cell_dl[gi] > cmd.key);
      if (gi == 0) begin : g_first
        assign prev_gt[gi] = 1'b0;
      end else begin : g_rest
        assign prev_gt[gi] = gt[gi-1];
      end

      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (prev_gt[gi]) begin
            cell_dl[gi] <= cell_dl[(gi == 0) ? 0 : gi - 1];
            cell_hd[gi] <= cell_hd[(gi == 0) ? 0 : gi - 1];
          end else if (gt[gi] || (count == CNT_W'(gi))) begin
            cell_dl[gi] <= cmd.key;
            cell_hd[gi] <= cmd.handle;
          end
        end else if (do_pop && (gi < QUEUE_DEPTH - 1)) begin
          cell_dl[gi] <= cell_dl[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
          cell_hd[gi] <= cell_hd[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rel_n        <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (do_start) begin
            state <= S_REL;
            rel_n <= '0;
            now_r <= cmd.key;
          end
        end
        S_REL: begin
          if (!head_exp) begin
            state <= S_IDLE;
          end else if (do_pop) begin
            rel_n <= rel_n + REL_W'(1);
            if (!next_exp) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (do_insert) begin
        count <= count + CNT_W'(1);
      end else if (do_pop) begin
        count <= count - CNT_W'(1);
      end

      if (do_reject) begin
        result_valid <= 1'b1;
        status       <= ST_REJECTED;
        out_handle   <= cmd.handle;
        out_deadline <= cmd.key;
        last         <= 1'b1;
      end else if (do_pop) begin
        result_valid <= 1'b1;
        status       <= ST_RELEASED;
        out_handle   <= cell_hd[0];
        out_deadline <= cell_dl[0];
        last         <= !next_exp;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/deadline_timer_queue.sv -----
`timescale 1ns / 1ps

// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// item     | item_valid / item_stall    | kind, deadline, handle, current_time
// result   | result_valid / result_stall| status, out_handle, out_deadline, last
//
// In an add, every cell of the timer chain compares its deadline
// against the new one in parallel and the later cells move up one place.
// A tick first registers its time, then the chain pops its head once per
// cycle while the result is not stalled (at most sixteen per tick) until no
// expired timer is left; a tick that finds nothing expired releases nothing.
// A two-beat command queue lets items arrive while a tick is still releasing;
// every beat is registered there before the chain takes it.
// rst is synchronous, active high; it empties the chain, the queue and the
// result register. A stalled result holds the chain; items keep queuing.

module deadline_timer_queue import dtq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                kind,
  input  logic [TIME_W-1:0]   deadline,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [TIME_W-1:0]   current_time,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                status,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [TIME_W-1:0]   out_deadline,
  output logic                last
);

  logic         cmd_valid;
  cmd_t         cmd;
  logic         cmd_take;
  back_status_t bstat;

  // Front: accept beats, classify them and queue the commands.
  dtq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .deadline     (deadline),
    .handle       (handle),
    .current_time (current_time),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Back: sorted timer chain, release sequencer and result register.
  dtq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .out_handle   (out_handle),
    .out_deadline (out_deadline),
    .last         (last),
    .bstat        (bstat)
  );

`ifndef SYNTH
  // A rejected add is always the only beat of its item.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_REJECTED) |-> last)
    else $error("reject beat without last");

  // The chain never holds more timers than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bstat.count <= CNT_W'(QUEUE_DEPTH))
    else $error("timer count overflow");

  // A released beat that is not last means the tick is still releasing.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> bstat.releasing)
    else $error("non-last beat after release ended");

  // No command is taken while a tick is releasing.
  a_no_take_rel: assert property (@(posedge clk) disable iff (rst)
    bstat.releasing |-> !cmd_take)
    else $error("command taken during release");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dtq_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam int                CYCLE_LIMIT = 300000;
  localparam int                HOLD_CYCLES = 300;
  localparam int                PHASE_ITEMS = 135;
  localparam int                SETTLE_CYC  = 60;
  localparam int                N_CUES      = 25;

  // One result beat as the block should send it.
  typedef struct packed {
    status_t             st;
    logic [HANDLE_W-1:0] hd;
    logic [TIME_W-1:0]   dl;
    logic                last;
  } wake_t;

  // One row of the directed table. When pinned is set, the row carries its own
  // answer: either nothing (has_wake low) or a single beat with last high.
  typedef struct packed {
    op_t                 op;
    logic [TIME_W-1:0]   dl;
    logic [HANDLE_W-1:0] hd;
    logic [TIME_W-1:0]   now;
    logic                pinned;
    logic                has_wake;
    status_t             w_st;
    logic [HANDLE_W-1:0] w_hd;
    logic [TIME_W-1:0]   w_dl;
  } cue_t;

  localparam cue_t CUES [N_CUES] = '{
    // empty store right after reset: ticks release nothing
    '{OP_TICK, TIME_MAX,      8'hFF, 48'h0,      1'b1, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_TICK, 48'h0,         8'h00, TIME_MAX,   1'b1, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    // both deadline extremes; adds into a store with room never answer
    '{OP_ADD,  48'h0,         8'h00, TIME_MAX,   1'b1, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  TIME_MAX,      8'hFF, 48'h0,      1'b1, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    // deadline equal to the tick time counts as expired
    '{OP_TICK, TIME_MAX,      8'hAA, 48'h0,      1'b1, 1'b1, ST_RELEASED, 8'h00, 48'h0},
    // equal deadlines leave in arrival order; only the one below the tick time leaves
    '{OP_ADD,  48'd100,       8'h01, 48'hDEAD,   1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd100,       8'h02, 48'hBEEF,   1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd50,        8'h03, TIME_MAX,   1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_TICK, 48'h1234,      8'h5A, 48'd99,     1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    // fill the store to the brim
    '{OP_ADD,  48'd200,       8'h10, 48'h1,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd100,       8'h11, 48'h2,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd1,         8'h12, 48'h3,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'h8000_0000_0000, 8'h80, 48'h4, 1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'h7FFF_FFFF_FFFF, 8'h7F, 48'h5, 1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'h5555_5555_5555, 8'h55, 48'h6, 1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'hAAAA_AAAA_AAAA, 8'hAA, 48'h7, 1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd300,       8'h13, 48'h8,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd300,       8'h14, 48'h9,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd2,         8'h15, 48'hA,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  TIME_MAX - 1,  8'h16, 48'hB,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'h0,         8'h17, 48'hC,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_ADD,  48'd99,        8'h18, 48'hD,      1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    // add into a full store bounces back with its own handle and deadline
    '{OP_ADD,  48'h0123_4567_89AB, 8'hEE, 48'hE, 1'b1, 1'b1, ST_REJECTED, 8'hEE,
      48'h0123_4567_89AB},
    // drain everything but the latest timer, then that one alone
    '{OP_TICK, 48'h0,         8'h00, TIME_MAX - 1, 1'b0, 1'b0, ST_RELEASED, 8'h00, 48'h0},
    '{OP_TICK, 48'h0,         8'h00, TIME_MAX,   1'b1, 1'b1, ST_RELEASED, 8'hFF, TIME_MAX}
  };

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  logic                kind         = OP_ADD;
  logic [TIME_W-1:0]   deadline     = '0;
  logic [HANDLE_W-1:0] handle       = '0;
  logic [TIME_W-1:0]   current_time = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                status;
  logic [HANDLE_W-1:0] out_handle;
  logic [TIME_W-1:0]   out_deadline;
  logic                last;

  deadline_timer_queue dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .deadline     (deadline),
    .handle       (handle),
    .current_time (current_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .out_handle   (out_handle),
    .out_deadline (out_deadline),
    .last         (last)
  );

  always #10 clk = ~clk;

  // Shadow copy of the timer store, kept in release order.
  logic [TIME_W-1:0]   pend_dl [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] pend_hd [QUEUE_DEPTH];
  int                  pend_n = 0;

  wake_t awaited_wakes [$];

  int     fault_cnt    = 0;
  int     cycle_cnt    = 0;
  int     tx_idle_pct  = 26;
  int     rx_idle_pct  = 65;
  logic   hold_arm     = 1'b0;
  logic   hold_started = 1'b0;
  int     hold_left    = 0;

  // Apply one accepted item to the shadow store and queue the beats it owes.
  function automatic void apply_to_timers(op_t op, logic [TIME_W-1:0] dl,
                                          logic [HANDLE_W-1:0] hd,
                                          logic [TIME_W-1:0] now);
    int    pos;
    int    n;
    wake_t w;
    if (op == OP_ADD) begin
      if (pend_n >= QUEUE_DEPTH) begin
        w = '{ST_REJECTED, hd, dl, 1'b1};
        awaited_wakes.push_back(w);
        return;
      end
      // slide later timers up; equal deadlines stay ahead of the new one
      pos = pend_n;
      while (pos > 0 && pend_dl[pos-1] > dl) begin
        pend_dl[pos] = pend_dl[pos-1];
        pend_hd[pos] = pend_hd[pos-1];
        pos--;
      end
      pend_dl[pos] = dl;
      pend_hd[pos] = hd;
      pend_n++;
    end else begin
      n = 0;
      while (n < pend_n && n < RESULT_LIMIT && pend_dl[n] <= now) begin
        w.st   = ST_RELEASED;
        w.hd   = pend_hd[n];
        w.dl   = pend_dl[n];
        w.last = (n + 1 >= pend_n) || (n + 1 >= RESULT_LIMIT) || (pend_dl[n+1] > now);
        awaited_wakes.push_back(w);
        n++;
      end
      for (int i = n; i < pend_n; i++) begin
        pend_dl[i-n] = pend_dl[i];
        pend_hd[i-n] = pend_hd[i];
      end
      pend_n -= n;
    end
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  task automatic note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Offer one beat: idle at random first, then hold it until accepted.
  // Returns in the time step of the accepting edge.
  task automatic offer_item(op_t op, logic [TIME_W-1:0] dl, logic [HANDLE_W-1:0] hd,
                            logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    kind         <= op;
    deadline     <= dl;
    handle       <= hd;
    current_time <= now;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Pause the sender until every owed beat has come back. Drop valid first so
  // the beat just accepted is not offered again.
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaited_wakes.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus one long hold-off counted here so the
  // chain backs up and pushes stall onto the item channel.
  always @(negedge clk) begin
    if (hold_arm && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Check every accepted result beat against the oldest owed one.
  always @(posedge clk) begin : check_wake
    wake_t w;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_wakes.size() == 0) begin
        note_fault($sformatf("unexpected beat st=%0d h=%02h dl=%012h last=%0d",
                             status, out_handle, out_deadline, last));
      end else begin
        w = awaited_wakes.pop_front();
        if (status !== w.st || out_handle !== w.hd || out_deadline !== w.dl ||
            last !== w.last)
          note_fault($sformatf(
            "mismatch: expected st=%0d h=%02h dl=%012h last=%0d, got st=%0d h=%02h dl=%012h last=%0d",
            w.st, w.hd, w.dl, w.last, status, out_handle, out_deadline, last));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0]   now_t;
    logic [TIME_W-1:0]   dl;
    logic [HANDLE_W-1:0] hd;
    int                  add_pct;
    int                  r;
    int                  mark;
    wake_t               w;

    // hold reset, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Pinned rows drop whatever the shadow store predicts and
    // owe the answer written in the row; the store is still advanced.
    for (int i = 0; i < N_CUES; i++) begin
      offer_item(CUES[i].op, CUES[i].dl, CUES[i].hd, CUES[i].now);
      mark = awaited_wakes.size();
      apply_to_timers(CUES[i].op, CUES[i].dl, CUES[i].hd, CUES[i].now);
      if (CUES[i].pinned) begin
        while (awaited_wakes.size() > mark) void'(awaited_wakes.pop_back());
        if (CUES[i].has_wake) begin
          w = '{CUES[i].w_st, CUES[i].w_hd, CUES[i].w_dl, 1'b1};
          awaited_wakes.push_back(w);
        end
      end
    end

    // Random part in three idling regimes. Time moves forward from a random
    // start; most adds land a little ahead of it so ticks release a few at a
    // time and ties are common. Add-heavy bursts fill the store and bounce.
    now_t = rand_time() >> 1;
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_arm    = 1'b1;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        add_pct = ((i / 30) % 2 == 1) ? 88 : 50;
        r  = $urandom_range(0, 99);
        hd = HANDLE_W'($urandom_range(0, 255));
        if (r < add_pct) begin
          if ($urandom_range(0, 99) < 10) dl = rand_time();
          else                            dl = now_t + TIME_W'($urandom_range(0, 48));
          offer_item(OP_ADD, dl, hd, rand_time());
          apply_to_timers(OP_ADD, dl, hd, current_time);
        end else begin
          if ($urandom_range(0, 99) < 12) begin
            dl = rand_time();
          end else begin
            now_t = now_t + TIME_W'($urandom_range(0, 40));
            dl    = now_t;
          end
          offer_item(OP_TICK, rand_time(), hd, dl);
          apply_to_timers(OP_TICK, deadline, hd, dl);
        end
        // one mid-phase pause until everything owed has come back
        if (ph == 0 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    wait_drained();
    // give a stray extra beat time to show up
    repeat (SETTLE_CYC) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
